FILE: design/mea_pkg.sv
`timescale 1ns / 1ps
// mea_pkg: shared types and codes for the mouse event accelerator.
// Used by every module of the block; depends on nothing.
package mea_pkg;

	localparam logic [2:0] EK_LEFT   = 3'd0;
	localparam logic [2:0] EK_MIDDLE = 3'd1;
	localparam logic [2:0] EK_RIGHT  = 3'd2;
	localparam logic [2:0] EK_X_REL  = 3'd3;
	localparam logic [2:0] EK_Y_REL  = 3'd4;
	localparam logic [2:0] EK_X_ABS  = 3'd5;
	localparam logic [2:0] EK_Y_ABS  = 3'd6;

	localparam logic [2:0] RK_PRESS   = 3'd0;
	localparam logic [2:0] RK_RELEASE = 3'd1;
	localparam logic [2:0] RK_MOTION  = 3'd2;
	localparam logic [2:0] RK_ABS_X   = 3'd3;
	localparam logic [2:0] RK_ABS_Y   = 3'd4;
	localparam logic [2:0] RK_ERROR   = 3'd5;

	localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_NUMERATOR   = 2'd1;
	localparam logic [1:0] CFG_DENOMINATOR = 2'd2;

	localparam int THR_W  = 15;
	localparam int RATIO_W = 8;
	localparam int VAL_W  = 16;
	localparam int PROD_W = VAL_W + RATIO_W;
	localparam int SUM_W  = PROD_W + 1;

	typedef struct packed {
		logic [2:0]              event_kind;
		logic signed [VAL_W-1:0] event_value;
	} mea_in_t;

	typedef struct packed {
		logic [2:0]              result_kind;
		logic [1:0]              button_number;
		logic signed [VAL_W-1:0] motion_x;
		logic signed [VAL_W-1:0] motion_y;
		logic signed [VAL_W-1:0] absolute_position;
	} mea_out_t;

	typedef struct packed {
		logic [THR_W-1:0]   threshold;
		logic [RATIO_W-1:0] numerator;
		logic [RATIO_W-1:0] denominator;
	} mea_cfg_t;

	typedef enum logic [2:0] {
		CMD_PRESS,
		CMD_RELEASE,
		CMD_MOT_X,
		CMD_MOT_Y,
		CMD_ABS_X,
		CMD_ABS_Y,
		CMD_ERROR
	} mea_op_t;

	typedef struct packed {
		mea_op_t                 op;
		logic [1:0]              button;
		logic signed [VAL_W-1:0] value;
	} mea_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} mea_bk_state_t;

endpackage

FILE: design/mea_front.sv
`timescale 1ns / 1ps
// mea_front: accepts input beats, tracks the pressed-button mask, drops
// redundant button events and classifies the rest into commands. Uses mea_pkg.
module mea_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mea_pkg::mea_in_t  in_data,
	output logic              push,
	output mea_pkg::mea_cmd_t push_data,
	input  logic              q_full
);
	import mea_pkg::*;

	logic [2:0] pressed_q;
	logic [2:0] btn_bit;
	logic       is_btn;
	logic       level;
	logic       accept;
	logic       drop;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign level    = (in_data.event_value != '0);
	assign is_btn   = in_data.event_kind inside {EK_LEFT, EK_MIDDLE, EK_RIGHT};

	always_comb begin
		btn_bit          = '0;
		drop             = 1'b0;
		push_data.op     = CMD_ERROR;
		push_data.button = '0;
		push_data.value  = in_data.event_value;
		case (in_data.event_kind)
			EK_LEFT, EK_MIDDLE, EK_RIGHT: begin
				btn_bit          = 3'b001 << in_data.event_kind;
				push_data.op     = level ? CMD_PRESS : CMD_RELEASE;
				push_data.button = in_data.event_kind[1:0] + 2'd1;
				drop             = (level == (|(pressed_q & btn_bit)));
			end
			EK_X_REL: push_data.op = CMD_MOT_X;
			EK_Y_REL: push_data.op = CMD_MOT_Y;
			EK_X_ABS: push_data.op = CMD_ABS_X;
			EK_Y_ABS: push_data.op = CMD_ABS_Y;
			default:  push_data.op = CMD_ERROR;
		endcase
	end

	assign push = accept && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
		end else if (accept && is_btn && !drop) begin
			pressed_q <= pressed_q ^ btn_bit;
		end
	end

	a_press_sets: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.op == CMD_PRESS
		|=> $countones(pressed_q) == $countones($past(pressed_q)) + 1)
		else $error("press did not set a mask bit");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.op == CMD_RELEASE
		|=> $countones(pressed_q) + 1 == $countones($past(pressed_q)))
		else $error("release did not clear a mask bit");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drop |=> $stable(pressed_q))
		else $error("dropped button event changed the mask");

endmodule

FILE: design/mea_queue.sv
`timescale 1ns / 1ps
// mea_queue: two-entry command queue between front and back.
// Uses mea_pkg for the command type.
module mea_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mea_pkg::mea_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output mea_pkg::mea_cmd_t pop_data
);
	import mea_pkg::*;

	mea_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

FILE: design/mea_back.sv
`timescale 1ns / 1ps
// mea_back: executes commands: threshold acceleration with a multiply, a
// two-bit-per-cycle divider and saturation; drives the output register. Uses mea_pkg.
module mea_back #(
	parameter int SAT_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mea_pkg::mea_cfg_t cfg,
	input  logic              cmd_valid,
	input  mea_pkg::mea_cmd_t cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output mea_pkg::mea_out_t out_data
);
	import mea_pkg::*;

	localparam logic [SUM_W-1:0] SAT_HI  = SUM_W'((64'd1 << (SAT_W - 1)) - 64'd1);
	localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(64'd1 << (SAT_W - 1));
	localparam int               DIV_STEPS = PROD_W / 2;
	localparam logic [3:0]       DIV_LAST  = 4'(DIV_STEPS - 1);

	mea_bk_state_t      state_q;
	mea_bk_state_t      state_d;
	logic               out_valid_q;
	mea_out_t           out_q;
	logic               out_free;
	logic               is_motion;
	logic               load_direct;
	logic               load_motion;
	logic               start;

	logic               neg_q;
	logic               y_q;
	logic               accel_q;
	logic [VAL_W-1:0]   mag_q;
	logic [VAL_W-1:0]   diff_q;
	logic [THR_W-1:0]   thr_q;
	logic [RATIO_W-1:0] num_q;
	logic [RATIO_W-1:0] den_q;
	logic [PROD_W-1:0]  div_q;
	logic [RATIO_W-1:0] rem_q;
	logic [3:0]         cnt_q;

	logic [VAL_W-1:0]   cmd_mag;
	logic [PROD_W-1:0]  div_d;
	logic [RATIO_W-1:0] rem_d;
	logic [RATIO_W:0]   part;
	logic [SUM_W-1:0]   r_mag;
	logic [SUM_W-1:0]   r_signed;
	mea_out_t           direct_out;
	mea_out_t           motion_out;

	assign out_free  = !out_valid_q || out_ready;
	assign is_motion = (cmd.op == CMD_MOT_X) || (cmd.op == CMD_MOT_Y);
	assign cmd_mag   = cmd.value[VAL_W-1] ? VAL_W'(-cmd.value) : cmd.value;

	// state and control
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (start) state_d = BK_MUL;
			BK_MUL:  state_d = BK_DIV;
			BK_DIV:  if (cnt_q == DIV_LAST) state_d = BK_DONE;
			BK_DONE: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		load_direct = 1'b0;
		load_motion = 1'b0;
		start       = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_pop     = cmd_valid && (is_motion || out_free);
				load_direct = cmd_valid && !is_motion && out_free;
				start       = cmd_valid && is_motion;
			end
			BK_DONE: load_motion = out_free;
			default: cmd_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_motion) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// two restoring division steps per cycle
	always_comb begin
		div_d = div_q;
		rem_d = rem_q;
		part  = '0;
		for (int i = 0; i < 2; i++) begin
			part  = {rem_d, div_d[PROD_W-1]};
			div_d = {div_d[PROD_W-2:0], 1'b0};
			if (part >= {1'b0, den_q}) begin
				part     = part - {1'b0, den_q};
				div_d[0] = 1'b1;
			end
			rem_d = part[RATIO_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				neg_q   <= (cmd.op == CMD_MOT_Y) ? !cmd.value[VAL_W-1] : cmd.value[VAL_W-1];
				y_q     <= (cmd.op == CMD_MOT_Y);
				mag_q   <= cmd_mag;
				accel_q <= (cmd_mag > VAL_W'(cfg.threshold));
				diff_q  <= cmd_mag - VAL_W'(cfg.threshold);
				thr_q   <= cfg.threshold;
				num_q   <= cfg.numerator;
				den_q   <= (cfg.denominator == '0) ? RATIO_W'(1) : cfg.denominator;
			end
			BK_MUL: begin
				div_q <= PROD_W'(diff_q) * PROD_W'(num_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			BK_DIV: begin
				div_q <= div_d;
				rem_q <= rem_d;
				cnt_q <= cnt_q + 4'd1;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	// final sum, sign and saturation
	always_comb begin
		r_mag = accel_q ? (SUM_W'(thr_q) + SUM_W'(div_q)) : SUM_W'(mag_q);
		if (!neg_q) begin
			r_signed = (r_mag > SAT_HI) ? SAT_HI : r_mag;
		end else begin
			r_signed = (r_mag > SAT_LIM) ? SUM_W'(-SAT_LIM) : SUM_W'(-r_mag);
		end
		motion_out                   = '0;
		motion_out.result_kind       = RK_MOTION;
		motion_out.motion_x          = y_q ? '0 : r_signed[VAL_W-1:0];
		motion_out.motion_y          = y_q ? r_signed[VAL_W-1:0] : '0;
	end

	always_comb begin
		direct_out = '0;
		case (cmd.op)
			CMD_PRESS: begin
				direct_out.result_kind   = RK_PRESS;
				direct_out.button_number = cmd.button;
			end
			CMD_RELEASE: begin
				direct_out.result_kind   = RK_RELEASE;
				direct_out.button_number = cmd.button;
			end
			CMD_ABS_X: begin
				direct_out.result_kind       = RK_ABS_X;
				direct_out.absolute_position = cmd.value;
			end
			CMD_ABS_Y: begin
				direct_out.result_kind       = RK_ABS_Y;
				direct_out.absolute_position = cmd.value;
			end
			default: direct_out.result_kind = RK_ERROR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_q <= direct_out;
		end else if (load_motion) begin
			out_q <= motion_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load_direct || load_motion) |-> out_free)
		else $error("output register overwritten");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> cnt_q <= DIV_LAST)
		else $error("divider ran past its last step");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_IDLE |-> !cmd_pop)
		else $error("command popped while busy");

endmodule

FILE: design/mouse_event_accelerator_unit.sv
`timescale 1ns / 1ps
// mouse_event_accelerator_unit: top level; configuration registers, front,
// command queue and back. Uses mea_pkg, mea_front, mea_queue, mea_back.
//
//   channel  signals                          direction  payload
//   input    in_valid / in_ready / in_data    in         mea_in_t
//   output   out_valid / out_ready / out_data out        mea_out_t
//   config   cfg_valid / cfg_ready            in         cfg_index, cfg_data
//
// Button, absolute and error events go from the head of the queue into the
// output register once it is free. A relative event passes one capture, one
// 16x8 multiply, a 2-bit-per-cycle divider and one saturate; the back takes
// no new command until its result is loaded. The front accepts while the
// two-entry queue has room. Reset clears the button mask and loads threshold
// 4, numerator 2, denominator 1. Config writes are always accepted.
module mouse_event_accelerator_unit #(
	parameter int DELTA_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mea_pkg::mea_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mea_pkg::mea_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import mea_pkg::*;

	localparam int SAT_W = (DELTA_WIDTH > VAL_W) ? VAL_W : ((DELTA_WIDTH < 2) ? 2 : DELTA_WIDTH);

	mea_cfg_t cfg_q;
	mea_cmd_t push_data;
	mea_cmd_t pop_data;
	logic     push;
	logic     q_full;
	logic     pop;
	logic     pop_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THR_W'(4);
			cfg_q.numerator   <= RATIO_W'(2);
			cfg_q.denominator <= RATIO_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data[THR_W-1:0];
				CFG_NUMERATOR:   cfg_q.numerator   <= cfg_data[RATIO_W-1:0];
				CFG_DENOMINATOR: cfg_q.denominator <= cfg_data[RATIO_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	mea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	mea_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	mea_back #(
		.SAT_W (SAT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (pop_valid),
		.cmd       (pop_data),
		.cmd_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: sim/mea_event_checker.sv
`timescale 1ns / 1ps
// mea_event_checker: watches the event, result and register channels of the
// mouse event accelerator, predicts each result and compares it on arrival.
// Depends on mea_pkg for the payload types and codes.
module mea_event_checker #(
	parameter int DELTA_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  mea_pkg::mea_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  mea_pkg::mea_out_t out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                mismatch_count,
	output int                pending,
	output int                results_seen
);
	import mea_pkg::*;

	logic [2:0]         held_buttons;
	logic [THR_W-1:0]   accel_thr;
	logic [RATIO_W-1:0] accel_num;
	logic [RATIO_W-1:0] accel_den;
	mea_out_t           expected_q[$];
	mea_out_t           predicted;
	mea_out_t           oldest;
	int                 fault_total;
	int                 result_total;

	function automatic longint scale_delta(input logic signed [VAL_W-1:0] delta);
		longint mag;
		longint divisor;
		longint scaled;
		mag = (delta < 0) ? -longint'(delta) : longint'(delta);
		divisor = (accel_den == 0) ? 1 : longint'(accel_den);
		scaled = mag;
		if (mag > longint'(accel_thr))
			scaled = longint'(accel_thr)
				+ ((mag - longint'(accel_thr)) * longint'(accel_num)) / divisor;
		return (delta < 0) ? -scaled : scaled;
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp_delta(input longint value);
		int     w;
		longint hi;
		longint lo;
		w = DELTA_WIDTH;
		if (w > 16) w = 16;
		if (w < 2) w = 2;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -(longint'(1) << (w - 1));
		if (value > hi) value = hi;
		else if (value < lo) value = lo;
		return value[VAL_W-1:0];
	endfunction

	// Return 0 when a button event leaves the button mask as it was.
	function automatic bit predict_event(input mea_in_t ev, output mea_out_t res);
		logic [2:0] button_mask;
		res = '0;
		res.result_kind = RK_ERROR;
		case (ev.event_kind)
		EK_LEFT, EK_MIDDLE, EK_RIGHT: begin
			button_mask = 3'b001 << ev.event_kind;
			if (ev.event_value == 0) begin
				if ((held_buttons & button_mask) == 0) return 1'b0;
				held_buttons = held_buttons & ~button_mask;
				res.result_kind = RK_RELEASE;
			end else begin
				if ((held_buttons & button_mask) != 0) return 1'b0;
				held_buttons = held_buttons | button_mask;
				res.result_kind = RK_PRESS;
			end
			res.button_number = ev.event_kind[1:0] + 2'd1;
		end
		EK_X_REL: begin
			res.result_kind = RK_MOTION;
			res.motion_x = clamp_delta(scale_delta(ev.event_value));
		end
		EK_Y_REL: begin
			res.result_kind = RK_MOTION;
			res.motion_y = clamp_delta(-scale_delta(ev.event_value));
		end
		EK_X_ABS: begin
			res.result_kind = RK_ABS_X;
			res.absolute_position = ev.event_value;
		end
		EK_Y_ABS: begin
			res.result_kind = RK_ABS_Y;
			res.absolute_position = ev.event_value;
		end
		default: ;
		endcase
		return 1'b1;
	endfunction

	task automatic check_field(input string field_name, input longint want,
		input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d",
				$time, field_name, want, got);
			fault_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_buttons = '0;
			accel_thr = 15'd4;
			accel_num = 8'd2;
			accel_den = 8'd1;
			expected_q.delete();
			fault_total = 0;
			result_total = 0;
			mismatch_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_THRESHOLD:   accel_thr = cfg_data[THR_W-1:0];
				CFG_NUMERATOR:   accel_num = cfg_data[RATIO_W-1:0];
				CFG_DENOMINATOR: accel_den = cfg_data[RATIO_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (predict_event(in_data, predicted))
					expected_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				result_total++;
				if (expected_q.size() == 0) begin
					$display({"%0t ns: unexpected result, expected none, ",
						"got kind %0d button %0d x %0d y %0d pos %0d"},
						$time, out_data.result_kind, out_data.button_number,
						out_data.motion_x, out_data.motion_y, out_data.absolute_position);
					fault_total++;
				end else begin
					oldest = expected_q.pop_front();
					check_field("result_kind", oldest.result_kind, out_data.result_kind);
					check_field("button_number", oldest.button_number,
						out_data.button_number);
					check_field("motion_x", oldest.motion_x, out_data.motion_x);
					check_field("motion_y", oldest.motion_y, out_data.motion_y);
					check_field("absolute_position", oldest.absolute_position,
						out_data.absolute_position);
				end
			end
			mismatch_count <= fault_total;
			results_seen <= result_total;
			pending <= expected_q.size();
		end
	end

endmodule

FILE: sim/mouse_event_accelerator_unit_test.sv
`timescale 1ns / 1ps
// mouse_event_accelerator_unit_test: drives mouse events and register writes
// into the accelerator and gives the verdict; results are judged by
// mea_event_checker. Depends on mea_pkg and the block's RTL.
module mouse_event_accelerator_unit_test;
	import mea_pkg::*;

	localparam int         DELTA_W         = 16;
	localparam int         IDLE_LIMIT      = 2000;
	localparam int         DRAIN_CYCLES    = 40;
	localparam int         LONG_HOLD       = 300;
	localparam int         HOLD_AFTER      = 60;
	localparam int         RANDOM_PHASES   = 10;
	localparam int         ITEMS_PER_PHASE = 150;
	localparam logic [1:0] CFG_UNUSED      = 2'd3;
	localparam logic [2:0] EK_UNKNOWN      = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	mea_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	mea_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          mismatch_count;
	int          pending;
	int          results_seen;
	int          sent_count;
	int          setting_count;
	int          idle_cycles;
	int          cur_thr;
	bit          steady;
	bit          long_hold_done;

	mouse_event_accelerator_unit #(.DELTA_WIDTH(DELTA_W)) dut (.*);

	mea_event_checker #(.DELTA_WIDTH(DELTA_W)) event_check (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_event(input logic [2:0] kind, input logic [15:0] value);
		mea_in_t beat;
		int      gap;
		beat.event_kind = kind;
		beat.event_value = value;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_accel(input logic [15:0] thr, input logic [15:0] num,
		input logic [15:0] den, input bit poke_unused);
		put_reg(CFG_THRESHOLD, thr);
		put_reg(CFG_NUMERATOR, num);
		put_reg(CFG_DENOMINATOR, den);
		if (poke_unused) put_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		cur_thr = int'(thr[14:0]);
		setting_count++;
	endtask

	// Drop valid, then hold until every expected result is back and the back is quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_event();
		int          r;
		int          mag;
		logic [2:0]  kind;
		logic [15:0] value;
		r = $urandom_range(0, 99);
		if (r < 36) begin
			kind = 3'($urandom_range(0, 2));
			value = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
		end else if (r < 76) begin
			kind = ($urandom_range(0, 1) != 0) ? EK_X_REL : EK_Y_REL;
			if ($urandom_range(0, 1) != 0) begin
				value = 16'($urandom);
			end else begin
				mag = cur_thr + int'($urandom_range(0, 20)) - 10;
				if (mag < 0) mag = 0;
				if (mag > 32767) mag = 32767;
				value = ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
			end
		end else if (r < 92) begin
			kind = ($urandom_range(0, 1) != 0) ? EK_X_ABS : EK_Y_ABS;
			value = 16'($urandom);
		end else begin
			kind = EK_UNKNOWN;
			value = 16'($urandom);
		end
		send_event(kind, value);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no beat for %0d cycles, %0d results outstanding",
				$time, IDLE_LIMIT, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stalls, open stretches and one long hold-off.
	initial begin
		int stall;
		out_ready <= 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && sent_count >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [15:0] thr;
		logic [15:0] num;
		logic [15:0] den;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sent_count = 0;
		setting_count = 1;
		cur_thr = 4;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: threshold 4, ratio 2/1
		send_event(EK_LEFT, 16'h0001);
		send_event(EK_LEFT, 16'h8000);
		send_event(EK_MIDDLE, 16'hFFFF);
		send_event(EK_RIGHT, 16'h7FFF);
		send_event(EK_LEFT, 16'h0000);
		send_event(EK_LEFT, 16'h0000);
		send_event(EK_MIDDLE, 16'h0000);
		send_event(EK_RIGHT, 16'h0000);
		send_event(EK_RIGHT, 16'h0000);
		send_event(EK_X_REL, 16'h7FFF);
		send_event(EK_X_REL, 16'h8000);
		send_event(EK_Y_REL, 16'h8000);
		send_event(EK_Y_REL, 16'h7FFF);
		send_event(EK_X_REL, 16'h0004);
		send_event(EK_X_REL, 16'h0005);
		send_event(EK_Y_REL, 16'hFFFB);
		send_event(EK_X_REL, 16'h0000);
		send_event(EK_Y_REL, 16'h0000);
		send_event(EK_X_ABS, 16'h8000);
		send_event(EK_Y_ABS, 16'h7FFF);
		send_event(EK_X_ABS, 16'h5555);
		send_event(EK_Y_ABS, 16'hAAAA);
		send_event(EK_UNKNOWN, 16'hAAAA);
		send_event(EK_UNKNOWN, 16'h5555);
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: begin
				thr = 16'd0; num = 16'd1; den = 16'd1;
			end
			1: begin
				thr = 16'd32767; num = 16'd255; den = 16'd1;
			end
			2: begin
				thr = 16'd0; num = 16'd255; den = 16'd1;
			end
			3: begin
				thr = 16'd1; num = 16'd1; den = 16'd255;
			end
			4: begin
				// upper bits masked off: threshold 5, numerator 0, denominator 3
				thr = 16'h8005; num = 16'h0100; den = 16'hFF03;
			end
			5: begin
				// denominator masks to 0 and acts as 1
				thr = 16'd16; num = 16'd7; den = 16'h0100;
			end
			default: begin
				case ($urandom_range(0, 3))
				0: thr = 16'($urandom_range(0, 15));
				1: thr = 16'($urandom_range(0, 32767));
				2: thr = 16'($urandom_range(100, 2000));
				default: thr = 16'd32767;
				endcase
				num = 16'($urandom_range(1, 255));
				den = 16'($urandom_range(1, 255));
			end
			endcase
			program_accel(thr, num, den, p == 4);
			steady = (p % 3 == 2);
			repeat (ITEMS_PER_PHASE) send_random_event();
			drain_results();
		end

		$display("Sent %0d mouse events under %0d accelerator settings, %0d results checked.",
			sent_count, setting_count, results_seen);
		$display("Covered redundant button levels, deltas near and far past the threshold, "
			, "saturation, zero ratio terms, absolute and unknown kinds, and stalls.");
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
